// ===== hdl/rtlg_pkg.sv =====
// ----------------------------------------------------------------------------
// rtlg_pkg
// Shared widths, register indexes and controller states of the row legaliser.
// ----------------------------------------------------------------------------
package rtlg_pkg;

    localparam int LEFT_W   = 24;
    localparam int ROWW_W   = 23;
    localparam int CWIDTH_W = 16;
    localparam int MARGIN_W = 16;
    localparam int OIDX_W   = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_LEFT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_MARGIN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_MARGIN = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SHIFT = 5'b00010,
        ST_FWD   = 5'b00100,
        ST_BWD   = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

endpackage

// ===== hdl/rtlg_ram.sv =====
// ----------------------------------------------------------------------------
// rtlg_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rtlg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/row_two_pass_contour_legalize.sv =====
// ----------------------------------------------------------------------------
// row_two_pass_contour_legalize
// Loads one row of cells, legalises them with a two-pass contour sweep and
// returns the final left edges in arrival order.
// ----------------------------------------------------------------------------
// Cells are taken one transaction at a time and kept sorted by left edge in
// the order RAM as they arrive: a cell moves every stored cell with a larger
// edge up one place, one entry per cycle, and a cell into an empty store is
// written directly. The cell flagged last_cell starts legalisation: a
// forward sweep over the order RAM into the placement RAM, a backward sweep
// that writes the final edges back into the order RAM by arrival index, then
// the results in arrival order, each further one fetched only as the sink
// takes the one before. A new row is accepted once the last result has been
// taken. A cell arriving into a full store is dropped; its last_cell flag
// still starts legalisation. Cell and contour arithmetic is exact and the
// result keeps its low 24 bits.
module row_two_pass_contour_legalize #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [rtlg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rtlg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [rtlg_pkg::LEFT_W-1:0]         s_cell_left,
    input  logic [rtlg_pkg::CWIDTH_W-1:0]       s_cell_width,
    input  logic                                s_last_cell,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rtlg_pkg::OIDX_W-1:0]         m_cell_index,
    output logic [rtlg_pkg::LEFT_W-1:0]         m_placed_left,
    output logic                                m_last_result
);
    import rtlg_pkg::*;

    localparam int IW  = $clog2(MAX_ITEMS);
    localparam int CNW = $clog2(MAX_ITEMS + 1);
    localparam int CW  = 26 + $clog2(MAX_ITEMS);
    localparam int AW  = LEFT_W + CWIDTH_W + IW;
    localparam int BW  = CW + CWIDTH_W + IW;
    localparam logic [CNW-1:0] MAX_CNT = CNW'(MAX_ITEMS);

    // configuration
    logic [LEFT_W-1:0]   row_left_reg;
    logic [ROWW_W-1:0]   row_width_reg;
    logic [MARGIN_W-1:0] left_margin_reg;
    logic [MARGIN_W-1:0] right_margin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_left_reg     <= '0;
            row_width_reg    <= '0;
            left_margin_reg  <= '0;
            right_margin_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ROW_LEFT:     row_left_reg     <= cfg_wdata[LEFT_W-1:0];
                REG_ROW_WIDTH:    row_width_reg    <= cfg_wdata[ROWW_W-1:0];
                REG_LEFT_MARGIN:  left_margin_reg  <= cfg_wdata[MARGIN_W-1:0];
                REG_RIGHT_MARGIN: right_margin_reg <= cfg_wdata[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    // memories
    logic          a_we, b_we;
    logic [IW-1:0] a_waddr, a_raddr, b_waddr, b_raddr;
    logic [AW-1:0] a_wdata, a_rdata;
    logic [BW-1:0] b_wdata, b_rdata;

    rtlg_ram #(.WIDTH(AW), .DEPTH(MAX_ITEMS)) u_order_ram (
        .aclk(aclk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
        .raddr(a_raddr), .rdata(a_rdata)
    );

    rtlg_ram #(.WIDTH(BW), .DEPTH(MAX_ITEMS)) u_place_ram (
        .aclk(aclk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
        .raddr(b_raddr), .rdata(b_rdata)
    );

    state_t                state_reg, state_next;
    logic [CNW-1:0]        count_reg, count_next;
    logic [CNW-1:0]        j_reg, j_next;
    logic [CNW-1:0]        k_reg, k_next;
    logic [CNW-1:0]        p_reg, p_next;
    logic                  v_reg, v_next;
    logic                  last_reg, last_next;
    logic [LEFT_W-1:0]     new_left_reg, new_left_next;
    logic [CWIDTH_W-1:0]   new_width_reg, new_width_next;
    logic signed [CW-1:0]  contour_reg, contour_next;
    logic                  pend_reg, pend_next;
    logic [IW-1:0]         pend_idx_reg, pend_idx_next;
    logic                  pend_last_reg, pend_last_next;
    logic                  m_valid_reg, m_valid_next;
    logic [OIDX_W-1:0]     m_idx_reg, m_idx_next;
    logic [LEFT_W-1:0]     m_left_reg, m_left_next;
    logic                  m_last_reg, m_last_next;

    logic [LEFT_W-1:0]     a_left;
    logic [CWIDTH_W-1:0]   a_width;
    logic signed [CW-1:0]  b_x;
    logic [CWIDTH_W-1:0]   b_width;
    logic [IW-1:0]         b_idx;
    logic signed [CW-1:0]  fwd_init, bwd_init;
    logic signed [CW-1:0]  f_left, f_x, b_w, b_r, b_res;

    assign a_left  = a_rdata[AW-1 -: LEFT_W];
    assign a_width = a_rdata[IW +: CWIDTH_W];
    assign b_x     = b_rdata[BW-1 -: CW];
    assign b_width = b_rdata[IW +: CWIDTH_W];
    assign b_idx   = b_rdata[IW-1:0];

    assign fwd_init = CW'($signed(row_left_reg)) + $signed(CW'(left_margin_reg));
    assign bwd_init = CW'($signed(row_left_reg)) + $signed(CW'(row_width_reg))
                    - $signed(CW'(right_margin_reg));

    assign f_left = CW'($signed(a_left));
    assign f_x    = (f_left > contour_reg) ? f_left : contour_reg;
    assign b_w    = $signed(CW'(b_width));
    assign b_r    = ((b_x + b_w) > contour_reg) ? contour_reg : (b_x + b_w);
    assign b_res  = b_r - b_w;

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_cell_index  = m_idx_reg;
    assign m_placed_left = m_left_reg;
    assign m_last_result = m_last_reg;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        p_next         = p_reg;
        v_next         = 1'b0;
        last_next      = last_reg;
        new_left_next  = new_left_reg;
        new_width_next = new_width_reg;
        contour_next   = contour_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        pend_last_next = pend_last_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_idx_next     = m_idx_reg;
        m_left_next    = m_left_reg;
        m_last_next    = m_last_reg;
        a_we    = 1'b0;
        a_waddr = j_reg[IW-1:0];
        a_wdata = {new_left_reg, new_width_reg, count_reg[IW-1:0]};
        a_raddr = k_reg[IW-1:0];
        b_we    = 1'b0;
        b_waddr = p_reg[IW-1:0];
        b_wdata = {f_x, a_width, a_rdata[IW-1:0]};
        b_raddr = IW'(count_reg - CNW'(1) - k_reg);

        case (state_reg)
            ST_IDLE: begin
                a_raddr = IW'(count_reg - CNW'(1));
                if (s_valid) begin
                    new_left_next  = s_cell_left;
                    new_width_next = s_cell_width;
                    last_next      = s_last_cell;
                    j_next         = count_reg;
                    k_next         = '0;
                    p_next         = '0;
                    contour_next   = fwd_init;
                    if (count_reg == MAX_CNT) begin
                        // store full: drop the cell
                        if (s_last_cell) state_next = ST_FWD;
                    end else if (count_reg == '0) begin
                        a_we       = 1'b1;
                        a_waddr    = '0;
                        a_wdata    = {s_cell_left, s_cell_width, IW'(0)};
                        count_next = CNW'(1);
                        if (s_last_cell) state_next = ST_FWD;
                    end else begin
                        state_next = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT: begin
                a_raddr = IW'(j_reg - CNW'(2));
                a_we    = 1'b1;
                if (j_reg != '0 && $signed(a_left) > $signed(new_left_reg)) begin
                    // move the larger entry up one place
                    a_wdata = a_rdata;
                    j_next  = j_reg - CNW'(1);
                end else begin
                    count_next = count_reg + CNW'(1);
                    state_next = last_reg ? ST_FWD : ST_IDLE;
                end
            end
            ST_FWD: begin
                if (k_reg < count_reg) begin
                    k_next = k_reg + CNW'(1);
                    v_next = 1'b1;
                end
                if (v_reg) begin
                    b_we         = 1'b1;
                    contour_next = f_x + $signed(CW'(a_width));
                    p_next       = p_reg + CNW'(1);
                    if (p_reg == count_reg - CNW'(1)) begin
                        state_next   = ST_BWD;
                        k_next       = '0;
                        p_next       = '0;
                        v_next       = 1'b0;
                        contour_next = bwd_init;
                    end
                end
            end
            ST_BWD: begin
                if (k_reg < count_reg) begin
                    k_next = k_reg + CNW'(1);
                    v_next = 1'b1;
                end
                if (v_reg) begin
                    a_we         = 1'b1;
                    a_waddr      = b_idx;
                    a_wdata      = {b_res[LEFT_W-1:0], CWIDTH_W'(0), IW'(0)};
                    contour_next = b_res;
                    p_next       = p_reg + CNW'(1);
                    if (p_reg == count_reg - CNW'(1)) begin
                        state_next = ST_EMIT;
                        k_next     = '0;
                        v_next     = 1'b0;
                    end
                end
            end
            ST_EMIT: begin
                if (pend_reg) begin
                    m_valid_next = 1'b1;
                    m_idx_next   = OIDX_W'(pend_idx_reg);
                    m_left_next  = a_left;
                    m_last_next  = pend_last_reg;
                end else if (!m_valid_reg || m_ready) begin
                    if (k_reg < count_reg) begin
                        pend_next      = 1'b1;
                        pend_idx_next  = k_reg[IW-1:0];
                        pend_last_next = (k_reg + CNW'(1) == count_reg);
                        k_next         = k_reg + CNW'(1);
                    end else begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            v_reg       <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            j_reg       <= '0;
            k_reg       <= '0;
            p_reg       <= '0;
            last_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            v_reg       <= v_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            p_reg       <= p_next;
            last_reg    <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        new_left_reg  <= new_left_next;
        new_width_reg <= new_width_next;
        contour_reg   <= contour_next;
        pend_idx_reg  <= pend_idx_next;
        pend_last_reg <= pend_last_next;
        m_idx_reg     <= m_idx_next;
        m_left_reg    <= m_left_next;
        m_last_reg    <= m_last_next;
    end

    a_idle_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("result pending while accepting cells");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_CNT)
        else $error("cell count beyond store depth");

    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_result) |=> (state_reg == ST_IDLE))
        else $error("row not closed after final result");

endmodule

// ===== tb/row_two_pass_contour_legalize_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_two_pass_contour_legalize_tb
// Drives rows of cells with random idling and stalls, predicts the legalised
// left edges of every row and checks each result transaction against them.
// ----------------------------------------------------------------------------
module row_two_pass_contour_legalize_tb;
    import rtlg_pkg::*;

    localparam int MAX_ITEMS = 64;

    typedef struct packed {
        logic [OIDX_W-1:0] cell_index;
        logic [LEFT_W-1:0] placed_left;
        logic              last_result;
    } placement_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [LEFT_W-1:0]     s_cell_left;
    logic [CWIDTH_W-1:0]   s_cell_width;
    logic                  s_last_cell;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [OIDX_W-1:0]     m_cell_index;
    logic [LEFT_W-1:0]     m_placed_left;
    logic                  m_last_result;

    row_two_pass_contour_legalize #(.MAX_ITEMS(MAX_ITEMS)) dut (.*);

    // predictor state
    longint     row_x0;
    longint     row_span;
    longint     margin_l;
    longint     margin_r;
    longint     row_cell_left[$];
    longint     row_cell_width[$];
    placement_t placement_q[$];

    int errors;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_len;
    int hold_off_req;
    int hold_off_ack = 0;
    int hold_off_cycles = 0;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // stable sort, forward sweep, backward sweep; queue results by arrival
    task automatic legalize_row();
        int     n;
        int     order[$];
        longint placed[$];
        longint contour;
        longint x;
        longint r;
        longint w;
        placement_t p;
        longint final_left[MAX_ITEMS];
        n = row_cell_left.size();
        for (int i = 0; i < n; i++) begin
            int j;
            j = order.size();
            while (j > 0 && row_cell_left[order[j-1]] > row_cell_left[i]) j--;
            order.insert(j, i);
        end
        contour = row_x0 + margin_l;
        for (int i = 0; i < n; i++) begin
            x = row_cell_left[order[i]] > contour ? row_cell_left[order[i]] : contour;
            placed.insert(placed.size(), x);
            contour = x + row_cell_width[order[i]];
        end
        contour = row_x0 + row_span - margin_r;
        for (int i = n - 1; i >= 0; i--) begin
            w = row_cell_width[order[i]];
            r = placed[i] + w;
            if (r > contour) r = contour;
            final_left[order[i]] = r - w;
            contour = r - w;
        end
        for (int a = 0; a < n; a++) begin
            p.cell_index  = a[OIDX_W-1:0];
            p.placed_left = final_left[a][LEFT_W-1:0];
            p.last_result = (a == n - 1);
            placement_q.insert(placement_q.size(), p);
        end
        row_cell_left.delete();
        row_cell_width.delete();
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_ROW_LEFT:     row_x0   = longint'(signed'(value[LEFT_W-1:0]));
            REG_ROW_WIDTH:    row_span = value[ROWW_W-1:0];
            REG_LEFT_MARGIN:  margin_l = value[MARGIN_W-1:0];
            REG_RIGHT_MARGIN: margin_r = value[MARGIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_row_setup(input longint x0, input longint span,
                                   input longint ml, input longint mr);
        write_reg(REG_ROW_LEFT, x0);
        write_reg(REG_ROW_WIDTH, span);
        write_reg(REG_LEFT_MARGIN, ml);
        write_reg(REG_RIGHT_MARGIN, mr);
    endtask

    // send one cell; called and returning at a falling edge, valid left high
    task automatic send_cell(input longint left, input longint width, input bit last);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_cell_left  <= left[LEFT_W-1:0];
        s_cell_width <= width[CWIDTH_W-1:0];
        s_last_cell  <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (row_cell_left.size() < MAX_ITEMS) begin
            row_cell_left.insert(row_cell_left.size(),
                                 longint'(signed'(left[LEFT_W-1:0])));
            row_cell_width.insert(row_cell_width.size(), width[CWIDTH_W-1:0]);
        end
        if (last) legalize_row();
        @(negedge aclk);
    endtask

    // drop valid and hold until every expected result has come
    task automatic drain();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (placement_q.size() != 0 && guard < 50000) begin
            @(negedge aclk);
            guard++;
        end
        if (placement_q.size() != 0)
            report_mismatch("results missing", placement_q.size(), 0);
        repeat (20) @(negedge aclk);
    endtask

    function automatic longint rand_left();
        case ($urandom_range(5))
            0: return -8388608;
            1: return 8388607;
            2: return longint'(signed'(24'($urandom)));
            default: return longint'($urandom_range(2000)) - 1000;
        endcase
    endfunction

    function automatic longint rand_width();
        case ($urandom_range(7))
            0: return 65535;
            1: return 0;
            2: return $urandom_range(65535, 1);
            default: return $urandom_range(60, 1);
        endcase
    endfunction

    task automatic send_random_row(input int n);
        for (int i = 0; i < n; i++) send_cell(rand_left(), rand_width(), i == n - 1);
    endtask

    always @(posedge aclk) begin
        placement_t want;
        if (aresetn && m_valid && m_ready) begin
            if (placement_q.size() == 0) begin
                report_mismatch("unexpected result index", m_cell_index, -1);
            end else begin
                want = placement_q.pop_front();
                if (m_cell_index !== want.cell_index)
                    report_mismatch("cell_index", m_cell_index, want.cell_index);
                if (m_placed_left !== want.placed_left)
                    report_mismatch("placed_left", m_placed_left, want.placed_left);
                if (m_last_result !== want.last_result)
                    report_mismatch("last_result", m_last_result, want.last_result);
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_off_req != hold_off_ack) begin
            hold_off_ack    <= hold_off_req;
            hold_off_cycles <= hold_off_len;
            m_ready         <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            m_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic test_directed_extremes();
        write_row_setup(0, 1000, 0, 0);
        send_cell(100, 10, 0);
        send_cell(100, 20, 0);
        send_cell(50, 0, 0);
        send_cell(-8388608, 65535, 0);
        send_cell(8388607, 1, 1);
        send_cell(0, 5, 1);
        drain();
        write_row_setup(-8388608, 8388607, 65535, 65535);
        send_cell(8388607, 65535, 0);
        send_cell(-8388608, 65535, 0);
        send_cell(24'h7FFFFF, 16'hFFFF, 1);
        drain();
        write_row_setup(8388607, 0, 0, 0);
        send_cell(-1, 3, 0);
        send_cell(1, 3, 1);
        drain();
    endtask

    task automatic test_full_store();
        write_row_setup(-500, 5000, 10, 20);
        for (int i = 0; i < MAX_ITEMS + 2; i++)
            send_cell(rand_left(), rand_width(), i == MAX_ITEMS + 1);
        drain();
    endtask

    // hold the sink off while the next row is already being offered
    task automatic test_backpressure();
        send_random_row(12);
        hold_off_len = 400;
        hold_off_req++;
        send_random_row(6);
        drain();
    endtask

    task automatic test_random_phase(input int idle, input int stall, input int rows);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        write_row_setup(longint'($urandom_range(2000)) - 1000, $urandom_range(4000),
                        $urandom_range(50), $urandom_range(50));
        for (int r = 0; r < rows; r++) send_random_row($urandom_range(8, 1));
        drain();
    endtask

    initial begin
        aresetn = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
        s_valid = 1'b0; s_cell_left = '0; s_cell_width = '0; s_last_cell = 1'b0;
        errors = 0; send_idle_pct = 0; recv_stall_pct = 0;
        hold_off_len = 0; hold_off_req = 0;
        row_x0 = 0; row_span = 0; margin_l = 0; margin_r = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed_extremes();
        test_full_store();
        test_backpressure();
        test_random_phase(0, 0, 2);
        test_random_phase(82, 0, 2);
        test_random_phase(0, 82, 2);
        test_random_phase(34, 34, 2);
        drain();
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
